// ----- hw/rtl/socd_pkg.sv -----
// Shared types and constants for the SOCD direction cleaner.
// Holds the action masks, the mode and winner codes and the input item struct.
// No dependencies.
package socd_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] MaskUp      = 32'h0000_0010;
  localparam logic [WordW-1:0] MaskDown    = 32'h0000_0020;
  localparam logic [WordW-1:0] MaskLeft    = 32'h0000_0040;
  localparam logic [WordW-1:0] MaskRight   = 32'h0000_0080;
  localparam logic [WordW-1:0] MaskFocus   = 32'h0000_0004;
  localparam logic [WordW-1:0] MaskShoot   = 32'h0000_8101;
  localparam logic [WordW-1:0] MaskBomb    = 32'h0000_0202;
  localparam logic [WordW-1:0] MaskSkip    = 32'h0000_0100;
  localparam logic [WordW-1:0] MaskConfirm = 32'h0000_0100;
  localparam logic [WordW-1:0] RemapMask   = MaskUp | MaskDown | MaskLeft | MaskRight |
                                             MaskFocus | MaskShoot | MaskBomb | MaskSkip |
                                             MaskConfirm;

  typedef enum logic [1:0] {
    MODE_BOTH    = 2'd0,
    MODE_LAST    = 2'd1,
    MODE_FIRST   = 2'd2,
    MODE_NEUTRAL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    WIN_NONE = 2'd0,
    WIN_NEG  = 2'd1,
    WIN_POS  = 2'd2
  } win_e;

  typedef struct packed {
    logic [WordW-1:0] native_actions;
    logic             up_held;
    logic             down_held;
    logic             left_held;
    logic             right_held;
    logic             focus_held;
    logic             shoot_held;
    logic             bomb_held;
    logic             skip_held;
    logic             confirm_held;
    logic             replay_playback;
    logic             binding_capture;
  } in_item_t;

endpackage

// ----- hw/rtl/socd_axis.sv -----
// SOCD resolver for one axis: previous held bits and the current winner.
// Depends on socd_pkg for the mode and winner codes.
module socd_axis (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  socd_pkg::mode_e mode_i,
  input  logic            en_i,
  input  logic            clr_i,
  input  logic            neg_i,
  input  logic            pos_i,
  output logic            neg_o,
  output logic            pos_o
);
  import socd_pkg::*;

  logic neg_was_q, pos_was_q;
  win_e win_q, win_d;
  win_e win_pick;
  logic rise_neg, rise_pos, may_take;

  assign rise_neg = neg_i & ~neg_was_q;
  assign rise_pos = pos_i & ~pos_was_q;
  assign may_take = (mode_i == MODE_LAST) || (win_q == WIN_NONE);

  always_comb begin
    win_pick = win_q;
    if (may_take && (rise_neg != rise_pos)) begin
      win_pick = rise_neg ? WIN_NEG : WIN_POS;
    end
  end

  always_comb begin
    win_d = win_q;
    neg_o = 1'b0;
    pos_o = 1'b0;
    case ({neg_i, pos_i})
      2'b00: win_d = WIN_NONE;
      2'b10: begin
        win_d = WIN_NEG;
        neg_o = 1'b1;
      end
      2'b01: begin
        win_d = WIN_POS;
        pos_o = 1'b1;
      end
      default: begin
        if (mode_i == MODE_BOTH) begin
          neg_o = 1'b1;
          pos_o = 1'b1;
        end else if (mode_i == MODE_NEUTRAL) begin
          win_d = WIN_NONE;
        end else begin
          win_d = win_pick;
          neg_o = (win_pick == WIN_NEG);
          pos_o = (win_pick == WIN_POS);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_was_q <= 1'b0;
      pos_was_q <= 1'b0;
      win_q     <= WIN_NONE;
    end else if (clr_i) begin
      neg_was_q <= 1'b0;
      pos_was_q <= 1'b0;
      win_q     <= WIN_NONE;
    end else if (en_i) begin
      neg_was_q <= neg_i;
      pos_was_q <= pos_i;
      win_q     <= win_d;
    end
  end

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (win_q == WIN_NONE) && !neg_was_q && !pos_was_q)
    else $error("axis state not cleared after mode write");

  a_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !clr_i && neg_i && pos_i && mode_i == MODE_NEUTRAL) |=> (win_q == WIN_NONE))
    else $error("neutral mode kept a winner");

  a_both_only_in_both_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (neg_o && pos_o) |-> (mode_i == MODE_BOTH))
    else $error("both directions passed outside both-pass mode");

endmodule

// ----- hw/rtl/socd_direction_cleaner.sv -----
// Top level of the SOCD direction cleaner: input register, merge logic, result register.
// Depends on socd_pkg and socd_axis.
//
// Usage: each input transfer carries one polled action word and nine button bits;
// each one yields exactly one output transfer with the cleaned word. Both channels
// use valid/stall: a transfer happens on a rising edge with valid high and stall low.
// An item goes from its input transfer through the input register, then the result
// register. Throughput is one item per cycle while out_stall_i is low; the two registers
// form a two-entry pipeline that only advances when the result register is empty or
// being taken, so an output stall backs up into in_stall_o after at most two items.
// The per-axis SOCD state is updated as an item that is neither replay playback nor
// binding capture moves into the result register, which keeps the updates in item order.
// The configuration channel writes socd_mode; cfg_ready_o is always high and any write
// clears the axis state. Writes are expected only while idle.
// Reset clears both pipeline valid flags, the axis state and sets socd_mode to
// both-pass.
module socd_direction_cleaner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [socd_pkg::WordW-1:0] native_actions_i,
  input  logic                      up_held_i,
  input  logic                      down_held_i,
  input  logic                      left_held_i,
  input  logic                      right_held_i,
  input  logic                      focus_held_i,
  input  logic                      shoot_held_i,
  input  logic                      bomb_held_i,
  input  logic                      skip_held_i,
  input  logic                      confirm_held_i,
  input  logic                      replay_playback_i,
  input  logic                      binding_capture_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [socd_pkg::WordW-1:0] merged_actions_o
);
  import socd_pkg::*;

  mode_e    mode_q;
  logic     cfg_wr;
  in_item_t item_q;
  logic     item_valid_q;
  logic     out_valid_q;
  logic [WordW-1:0] out_q, out_d;
  logic     advance, in_xfer, axis_en;
  logic     up_bit, down_bit, left_bit, right_bit;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign axis_en    = item_valid_q && advance &&
                      !item_q.replay_playback && !item_q.binding_capture;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BOTH;
    end else if (cfg_wr) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      // An empty input register takes a transfer even while the result is stalled.
      if (advance || !item_valid_q) begin
        item_valid_q <= in_xfer;
      end
      if (advance) begin
        out_valid_q  <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.native_actions  <= native_actions_i;
      item_q.up_held         <= up_held_i;
      item_q.down_held       <= down_held_i;
      item_q.left_held       <= left_held_i;
      item_q.right_held      <= right_held_i;
      item_q.focus_held      <= focus_held_i;
      item_q.shoot_held      <= shoot_held_i;
      item_q.bomb_held       <= bomb_held_i;
      item_q.skip_held       <= skip_held_i;
      item_q.confirm_held    <= confirm_held_i;
      item_q.replay_playback <= replay_playback_i;
      item_q.binding_capture <= binding_capture_i;
    end
    if (advance && item_valid_q) begin
      out_q <= out_d;
    end
  end

  socd_axis u_vert (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .en_i   (axis_en),
    .clr_i  (cfg_wr),
    .neg_i  (item_q.up_held),
    .pos_i  (item_q.down_held),
    .neg_o  (up_bit),
    .pos_o  (down_bit)
  );

  socd_axis u_horiz (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .en_i   (axis_en),
    .clr_i  (cfg_wr),
    .neg_i  (item_q.left_held),
    .pos_i  (item_q.right_held),
    .neg_o  (left_bit),
    .pos_o  (right_bit)
  );

  always_comb begin
    if (item_q.replay_playback) begin
      out_d = item_q.native_actions;
    end else begin
      out_d = item_q.native_actions & ~RemapMask;
      if (!item_q.binding_capture) begin
        out_d = out_d
              | (up_bit                ? MaskUp      : '0)
              | (down_bit              ? MaskDown    : '0)
              | (left_bit              ? MaskLeft    : '0)
              | (right_bit             ? MaskRight   : '0)
              | (item_q.focus_held     ? MaskFocus   : '0)
              | (item_q.shoot_held     ? MaskShoot   : '0)
              | (item_q.bomb_held      ? MaskBomb    : '0)
              | (item_q.skip_held      ? MaskSkip    : '0)
              | (item_q.confirm_held   ? MaskConfirm : '0);
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign merged_actions_o = out_q;

  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> item_valid_q && $stable(item_q))
    else $error("stalled item in the input register was lost or changed");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled result was lost or changed");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline had room");

endmodule
